[src/gftq_pkg.sv]
package gftq_pkg;

    localparam int NUM_GROUPS   = 16;
    localparam int GROUP_DEPTH  = 64;
    localparam int ELEMENT_BITS = 32;

    localparam int GID_W    = 4;
    localparam int ELEM_W   = 32;
    localparam int GROUP_W  = $clog2(NUM_GROUPS);
    localparam int GSEL_W   = (GROUP_W > GID_W) ? GROUP_W : GID_W;
    localparam int PTR_W    = $clog2(GROUP_DEPTH);
    localparam int CNT_W    = $clog2(GROUP_DEPTH + 1);
    localparam int OCNT_W   = $clog2(NUM_GROUPS + 1);
    localparam int ADDR_W   = $clog2(NUM_GROUPS * GROUP_DEPTH);
    localparam int MEM_DEPTH = NUM_GROUPS * GROUP_DEPTH;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [GROUP_W-1:0]   grp;
        logic [ADDR_W-1:0]    addr;
        logic                 wr_en;
        logic                 rd_en;
    } ctrl_t;

endpackage

[src/gftq_ctrl.sv]
module gftq_ctrl
    import gftq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic             func,
    input  logic [GID_W-1:0] group_id,
    output ctrl_t            ctrl
);

    logic [GROUP_W-1:0] order_queue_reg [NUM_GROUPS];
    logic [GROUP_W-1:0] order_head_reg;
    logic [GROUP_W-1:0] order_tail_reg;
    logic [OCNT_W-1:0]  order_count_reg;
    logic [PTR_W-1:0]   group_head_reg  [NUM_GROUPS];
    logic [PTR_W-1:0]   group_tail_reg  [NUM_GROUPS];
    logic [CNT_W-1:0]   group_count_reg [NUM_GROUPS];

    logic [GSEL_W-1:0]  gid_ext;
    logic               in_range;
    logic [GROUP_W-1:0] gidx;
    logic [GROUP_W-1:0] front;
    logic [GROUP_W-1:0] sel;
    logic [CNT_W-1:0]   cnt;
    logic [PTR_W-1:0]   ptr;
    logic               enq_ok;
    logic               deq_ok;
    logic [ADDR_W-1:0]  base;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] v);
        return (v == PTR_W'(GROUP_DEPTH - 1)) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [GROUP_W-1:0] ord_inc(input logic [GROUP_W-1:0] v);
        return (v == GROUP_W'(NUM_GROUPS - 1)) ? '0 : v + 1'b1;
    endfunction

    always_comb
    begin
        gid_ext  = GSEL_W'(group_id);
        in_range = (GSEL_W + 1)'(gid_ext) < (GSEL_W + 1)'(NUM_GROUPS);
        gidx     = gid_ext[GROUP_W-1:0];
        front    = order_queue_reg[order_head_reg];
        sel      = (func == FUNC_DEQ) ? front : gidx;
        cnt      = group_count_reg[sel];
        ptr      = (func == FUNC_DEQ) ? group_head_reg[sel] : group_tail_reg[sel];
        enq_ok   = (func == FUNC_ENQ) && in_range && (cnt < CNT_W'(GROUP_DEPTH));
        deq_ok   = (func == FUNC_DEQ) && (order_count_reg != '0) && (cnt != '0);
        base     = ADDR_W'(sel) * ADDR_W'(GROUP_DEPTH);

        ctrl.addr  = base + ADDR_W'(ptr);
        ctrl.grp   = sel;
        ctrl.wr_en = fire && enq_ok;
        ctrl.rd_en = fire && deq_ok;
        if (func == FUNC_DEQ)
        begin
            ctrl.status = deq_ok ? ST_OK : ST_EMPTY;
        end
        else
        begin
            ctrl.status = enq_ok ? ST_OK : ST_FULL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && enq_ok && (cnt == '0))
        begin
            order_queue_reg[order_tail_reg] <= gidx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_head_reg  <= '0;
            order_tail_reg  <= '0;
            order_count_reg <= '0;
            for (int i = 0; i < NUM_GROUPS; i++)
            begin
                group_head_reg[i]  <= '0;
                group_tail_reg[i]  <= '0;
                group_count_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            if (enq_ok)
            begin
                if (cnt == '0)
                begin
                    order_tail_reg  <= ord_inc(order_tail_reg);
                    order_count_reg <= order_count_reg + 1'b1;
                end
                group_tail_reg[sel]  <= ptr_inc(ptr);
                group_count_reg[sel] <= cnt + 1'b1;
            end
            else if (deq_ok)
            begin
                if (cnt == CNT_W'(1))
                begin
                    order_head_reg  <= ord_inc(order_head_reg);
                    order_count_reg <= order_count_reg - 1'b1;
                end
                group_head_reg[sel]  <= ptr_inc(ptr);
                group_count_reg[sel] <= cnt - 1'b1;
            end
        end
    end

endmodule

[src/grouped_fifo_team_queue.sv]
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------
// input    | in_valid / in_stall   | func, group_id, element
// output   | out_valid / out_stall | status, out_element, out_group
//
// One request per cycle sustained while the output is not stalled. Each
// request does bookkeeping and the element RAM read at the accepting edge,
// and its result then moves to the output register. The element RAM's read
// port is registered.
// Reset empties every group and the order queue; RAM contents stay as is.
// A stalled output holds its result; input stalls only when both stages
// are full and the output is stalled.
module grouped_fifo_team_queue
    import gftq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [GID_W-1:0]  group_id,
    input  logic [ELEM_W-1:0] element,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [ELEM_W-1:0] out_element,
    output logic [GID_W-1:0]  out_group
);

    ctrl_t                   ctrl;
    logic                    fire;
    logic                    s1_adv;

    logic [ELEMENT_BITS-1:0] mem [MEM_DEPTH];
    logic [ELEMENT_BITS-1:0] rd_data_reg;

    logic                    s1_valid_reg;
    status_t                 s1_status_reg;
    logic [GROUP_W-1:0]      s1_grp_reg;
    logic                    s1_deq_reg;

    logic                    out_valid_reg;
    logic [1:0]              status_reg;
    logic [ELEM_W-1:0]       out_element_reg;
    logic [GID_W-1:0]        out_group_reg;

    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign fire     = in_valid && !in_stall;

    gftq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .func     (func),
        .group_id (group_id),
        .ctrl     (ctrl)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.addr] <= ELEMENT_BITS'(element);
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_status_reg <= ctrl.status;
            s1_grp_reg    <= ctrl.grp;
            s1_deq_reg    <= ctrl.rd_en;
        end
        if (s1_valid_reg && s1_adv)
        begin
            status_reg      <= 2'(s1_status_reg);
            out_element_reg <= s1_deq_reg ? ELEM_W'(rd_data_reg) : '0;
            out_group_reg   <= s1_deq_reg ? GID_W'(s1_grp_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_element = out_element_reg;
    assign out_group   = out_group_reg;

endmodule
